/* hw/rtl/tpssa_pkg.sv */
// ============================================================================
// tpssa_pkg - shared types and constants of the two-pool slot size allocator
// Holds the command and pool codes, the sequencer states, the scan status
// bundle and the fixed size thresholds.
// ============================================================================
package tpssa_pkg;

    // Command codes carried on mode
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_REALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // Pool codes carried on region and out_region
    localparam logic [1:0] REGION_EXT   = 2'd0;
    localparam logic [1:0] REGION_SMALL = 2'd1;
    localparam logic [1:0] REGION_BIG   = 2'd2;

    localparam int SLOTS_PER_BLOCK = 4;

    // Size limits: below SMALL_LIMIT fits a small slot, below BIG_LIMIT a big one
    localparam logic [31:0] SMALL_LIMIT = 32'h0000_0010;
    localparam logic [31:0] BIG_LIMIT   = 32'h0000_0100;

    // Copy length reported when a big slot moves out
    localparam logic [8:0] COPY_BIG = 9'h100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_status_t;

endpackage

/* hw/rtl/tpssa_ram.sv */
// ============================================================================
// tpssa_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
module tpssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tpssa_scan.sv */
// ============================================================================
// tpssa_scan - first-free slot scanner
// Steps one occupancy flag per cycle while step is high, via a shared counter
// and compare, stopping at the first free slot or the last slot of the pool.
// ============================================================================
module tpssa_scan
    import tpssa_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             step,
    input  logic             flag,
    input  logic [IDX_W-1:0] last,
    output logic [IDX_W-1:0] idx,
    output scan_status_t     status
);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    always_comb
    begin
        status.hit  = step && !flag;
        status.done = step && (!flag || (cnt_reg == last));
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = '0;
        end
        else if (step && !status.done)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign idx = cnt_reg;

endmodule

/* hw/rtl/two_pool_slot_size_allocator_core.sv */
// ============================================================================
// two_pool_slot_size_allocator_core - slot allocator for a small and a big pool
// Tracks recorded sizes of SMALL_SLOTS 16-byte slots and BLOCKS*4 256-byte
// slots and serves alloc, realloc, free and query commands.
// ============================================================================
// Usage: raise start with a command while busy is low; the item is taken at
// that edge. Its result shows for exactly one cycle with done high and must be
// captured then, since the block cannot be stalled. Free, query, realloc that
// stays in place or moves out to the external allocator, and alloc that goes
// external pass through the READ and EXEC states to the result register. Alloc
// into a pool and realloc from the small pool into the big pool also pass
// through the SCAN state, where the first-free scanner visits occupancy flags
// up to the first free slot, at most SMALL_SLOTS for the small pool and
// BLOCKS*4 for the big pool, one flag per cycle. A new start is taken in the
// cycle done is high. Recorded sizes sit in two RAMs with registered reads;
// per-slot occupancy flags are flops cleared by reset, so the pools are free
// right after reset with no clearing pass.
// ============================================================================
module two_pool_slot_size_allocator_core
    import tpssa_pkg::*;
#(
    parameter int BLOCKS      = 16,
    parameter int SMALL_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [1:0]  region,
    input  logic [3:0]  block_index,
    input  logic [2:0]  slot_index,
    input  logic [7:0]  offset,
    input  logic [31:0] size,
    output logic        done,
    output logic [1:0]  out_region,
    output logic [3:0]  out_block,
    output logic [2:0]  out_slot,
    output logic        moved,
    output logic [8:0]  copy_bytes,
    output logic [7:0]  stored_size,
    output logic        known,
    output logic        valid_res
);

    localparam int BIG_COUNT = BLOCKS * SLOTS_PER_BLOCK;
    localparam int BIG_IW    = $clog2(BIG_COUNT);
    localparam int SMALL_IW  = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
    localparam int IDX_W     = (BIG_IW > SMALL_IW) ? BIG_IW : SMALL_IW;
    localparam logic [IDX_W-1:0] BIG_LAST   = IDX_W'(BIG_COUNT - 1);
    localparam logic [IDX_W-1:0] SMALL_LAST = IDX_W'(SMALL_SLOTS - 1);

    // ------------------------------------------------------------------
    // Captured item
    // ------------------------------------------------------------------
    logic [1:0]  mode_reg;
    logic [1:0]  region_reg;
    logic [3:0]  blk_reg;
    logic [2:0]  slt_reg;
    logic [7:0]  offset_reg;
    logic [31:0] size_reg;
    logic [3:0]  old_reg;

    state_t state_reg;
    state_t state_next;

    logic accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            region_reg <= region;
            blk_reg    <= block_index;
            slt_reg    <= slot_index;
            offset_reg <= offset;
            size_reg   <= size;
        end
    end

    // ------------------------------------------------------------------
    // Decode of the captured item
    // ------------------------------------------------------------------
    logic                is_small;
    logic                is_big;
    logic [SMALL_IW-1:0] slt_small_idx;
    logic [9:0]          bi_wide;
    logic [BIG_IW-1:0]   bi;
    logic                size_zero;
    logic                size_lt16;
    logic                size_lt256;
    logic                alloc_pool;
    logic                realloc_move;
    logic                scan_big;

    assign is_small      = (region_reg == REGION_SMALL) && (32'(slt_reg) < SMALL_SLOTS);
    assign is_big        = (region_reg == REGION_BIG) && (32'(blk_reg) < BLOCKS)
                           && (32'(slt_reg) < SLOTS_PER_BLOCK);
    assign slt_small_idx = slt_reg[SMALL_IW-1:0];
    assign bi_wide       = {4'd0, blk_reg, slt_reg[1:0]};
    assign bi            = bi_wide[BIG_IW-1:0];
    assign size_zero     = (size_reg == '0);
    assign size_lt16     = (size_reg < SMALL_LIMIT);
    assign size_lt256    = (size_reg < BIG_LIMIT);
    // alloc that needs a scan: any size from 1 to 255
    assign alloc_pool    = !size_zero && size_lt256;
    // small realloc into the big pool
    assign realloc_move  = is_small && !size_lt16 && size_lt256;
    // sizes of 16 and above scan the big pool
    assign scan_big      = !size_lt16;

    // ------------------------------------------------------------------
    // Occupancy flags and size RAMs
    // ------------------------------------------------------------------
    logic [SMALL_SLOTS-1:0] small_valid_reg;
    logic [SMALL_SLOTS-1:0] small_valid_next;
    logic [BIG_COUNT-1:0]   big_valid_reg;
    logic [BIG_COUNT-1:0]   big_valid_next;

    logic                small_wr;
    logic [SMALL_IW-1:0] small_wr_idx;
    logic [3:0]          small_wr_data;
    logic                small_clr;
    logic [SMALL_IW-1:0] small_clr_idx;
    logic                big_wr;
    logic [BIG_IW-1:0]   big_wr_idx;
    logic [7:0]          big_wr_data;
    logic                big_clr;
    logic [BIG_IW-1:0]   big_clr_idx;

    logic [3:0] small_rdata;
    logic [7:0] big_rdata;
    logic [3:0] small_old;
    logic [7:0] big_old;

    // Addresses come from the captured item; data is ready in the EXEC cycle
    tpssa_ram #(
        .WIDTH (4),
        .DEPTH (SMALL_SLOTS)
    ) u_small_ram (
        .clk   (clk),
        .we    (small_wr),
        .waddr (small_wr_idx),
        .wdata (small_wr_data),
        .raddr (slt_small_idx),
        .rdata (small_rdata)
    );

    tpssa_ram #(
        .WIDTH (8),
        .DEPTH (BIG_COUNT)
    ) u_big_ram (
        .clk   (clk),
        .we    (big_wr),
        .waddr (big_wr_idx),
        .wdata (big_wr_data),
        .raddr (bi),
        .rdata (big_rdata)
    );

    // A slot whose flag is clear reads as free, whatever the RAM holds
    assign small_old = small_valid_reg[slt_small_idx] ? small_rdata : 4'd0;
    assign big_old   = big_valid_reg[bi] ? big_rdata : 8'd0;

    always_comb
    begin
        small_valid_next = small_valid_reg;
        if (small_wr)
        begin
            small_valid_next[small_wr_idx] = |small_wr_data;
        end
        if (small_clr)
        begin
            small_valid_next[small_clr_idx] = 1'b0;
        end
    end

    always_comb
    begin
        big_valid_next = big_valid_reg;
        if (big_wr)
        begin
            big_valid_next[big_wr_idx] = |big_wr_data;
        end
        if (big_clr)
        begin
            big_valid_next[big_clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_valid_reg <= '0;
            big_valid_reg   <= '0;
        end
        else
        begin
            small_valid_reg <= small_valid_next;
            big_valid_reg   <= big_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // First-free scanner, shared by both pools
    // ------------------------------------------------------------------
    logic             scan_load;
    logic             scan_step;
    logic             scan_flag;
    logic [IDX_W-1:0] scan_last;
    logic [IDX_W-1:0] scan_idx;
    logic [9:0]       scan_idx_w;
    scan_status_t     scan_status;

    assign scan_last  = scan_big ? BIG_LAST : SMALL_LAST;
    assign scan_flag  = scan_big ? big_valid_reg[scan_idx[BIG_IW-1:0]]
                                 : small_valid_reg[scan_idx[SMALL_IW-1:0]];
    assign scan_idx_w = 10'(scan_idx);

    tpssa_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (scan_load),
        .step   (scan_step),
        .flag   (scan_flag),
        .last   (scan_last),
        .idx    (scan_idx),
        .status (scan_status)
    );

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (((mode_reg == MODE_ALLOC) && alloc_pool)
                    || ((mode_reg == MODE_REALLOC) && realloc_move))
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: actions and result
    // ------------------------------------------------------------------
    logic       res_load;
    logic [1:0] res_region_next;
    logic [3:0] res_block_next;
    logic [2:0] res_slot_next;
    logic       res_moved_next;
    logic [8:0] res_copy_next;
    logic [7:0] res_stored_next;
    logic       res_known_next;
    logic       res_valid_next;
    logic       old_load;

    always_comb
    begin
        res_load        = 1'b0;
        res_region_next = REGION_EXT;
        res_block_next  = 4'd0;
        res_slot_next   = 3'd0;
        res_moved_next  = 1'b0;
        res_copy_next   = 9'd0;
        res_stored_next = 8'd0;
        res_known_next  = 1'b0;
        res_valid_next  = 1'b0;
        small_wr        = 1'b0;
        small_wr_idx    = slt_small_idx;
        small_wr_data   = size_reg[3:0];
        small_clr       = 1'b0;
        small_clr_idx   = slt_small_idx;
        big_wr          = 1'b0;
        big_wr_idx      = bi;
        big_wr_data     = size_reg[7:0];
        big_clr         = 1'b0;
        big_clr_idx     = bi;
        scan_load       = 1'b0;
        scan_step       = 1'b0;
        old_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_READ:
            begin
            end
            ST_EXEC:
            begin
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (alloc_pool)
                        begin
                            scan_load = 1'b1;
                        end
                        else
                        begin
                            // zero or oversized request goes external
                            res_load = 1'b1;
                        end
                    end
                    MODE_REALLOC:
                    begin
                        if (is_small && size_lt16)
                        begin
                            // resize in place; zero leaves the slot free
                            small_wr        = 1'b1;
                            res_load        = 1'b1;
                            res_region_next = REGION_SMALL;
                            res_slot_next   = slt_reg;
                        end
                        else if (realloc_move)
                        begin
                            // hold the old size until the big slot is found
                            old_load  = 1'b1;
                            scan_load = 1'b1;
                        end
                        else if (is_small)
                        begin
                            // move out to the external allocator
                            small_clr      = 1'b1;
                            res_load       = 1'b1;
                            res_moved_next = 1'b1;
                            res_copy_next  = {5'd0, small_old};
                        end
                        else if (is_big && size_lt256)
                        begin
                            big_wr          = 1'b1;
                            res_load        = 1'b1;
                            res_region_next = REGION_BIG;
                            res_block_next  = blk_reg;
                            res_slot_next   = slt_reg;
                        end
                        else if (is_big)
                        begin
                            big_clr        = 1'b1;
                            res_load       = 1'b1;
                            res_moved_next = 1'b1;
                            res_copy_next  = COPY_BIG;
                        end
                        else
                        begin
                            res_load = 1'b1;
                        end
                    end
                    MODE_FREE:
                    begin
                        small_clr = is_small;
                        big_clr   = is_big;
                        res_load  = 1'b1;
                    end
                    MODE_QUERY:
                    begin
                        res_load = 1'b1;
                        if (is_small || is_big)
                        begin
                            res_stored_next = is_small ? {4'd0, small_old} : big_old;
                            res_known_next  = 1'b1;
                            res_valid_next  = (offset_reg < res_stored_next);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SCAN:
            begin
                scan_step = 1'b1;
                if (scan_status.done)
                begin
                    res_load = 1'b1;
                    if (scan_status.hit)
                    begin
                        if (scan_big)
                        begin
                            big_wr          = 1'b1;
                            big_wr_idx      = scan_idx[BIG_IW-1:0];
                            res_region_next = REGION_BIG;
                            res_block_next  = scan_idx_w[5:2];
                            res_slot_next   = {1'b0, scan_idx_w[1:0]};
                        end
                        else
                        begin
                            small_wr        = 1'b1;
                            small_wr_idx    = scan_idx[SMALL_IW-1:0];
                            res_region_next = REGION_SMALL;
                            res_slot_next   = scan_idx_w[2:0];
                        end
                    end
                    if (mode_reg == MODE_REALLOC)
                    begin
                        // release the old small slot once the new place is known
                        small_clr      = 1'b1;
                        res_moved_next = 1'b1;
                        res_copy_next  = {5'd0, old_reg};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (old_load)
        begin
            old_reg <= small_old;
        end
    end

    // ------------------------------------------------------------------
    // Result register: each item shows for exactly one cycle
    // ------------------------------------------------------------------
    logic       done_reg;
    logic [1:0] res_region_reg;
    logic [3:0] res_block_reg;
    logic [2:0] res_slot_reg;
    logic       res_moved_reg;
    logic [8:0] res_copy_reg;
    logic [7:0] res_stored_reg;
    logic       res_known_reg;
    logic       res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_region_reg <= res_region_next;
            res_block_reg  <= res_block_next;
            res_slot_reg   <= res_slot_next;
            res_moved_reg  <= res_moved_next;
            res_copy_reg   <= res_copy_next;
            res_stored_reg <= res_stored_next;
            res_known_reg  <= res_known_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    assign done        = done_reg;
    assign out_region  = res_region_reg;
    assign out_block   = res_block_reg;
    assign out_slot    = res_slot_reg;
    assign moved       = res_moved_reg;
    assign copy_bytes  = res_copy_reg;
    assign stored_size = res_stored_reg;
    assign known       = res_known_reg;
    assign valid_res   = res_valid_reg;

endmodule

/* tb/two_pool_slot_size_allocator_core_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// two_pool_slot_size_allocator_core_test - self-checking bench for the allocator
// Drives alloc, realloc, free and query items through the start/busy handshake,
// predicts every result from a local copy of both pools' recorded sizes, and
// checks each done strobe field by field against the oldest prediction.
// ============================================================================
module two_pool_slot_size_allocator_core_test;
    import tpssa_pkg::*;

    localparam int BLOCKS         = 16;
    localparam int SMALL_SLOTS    = 8;
    localparam int BIG_SLOTS      = BLOCKS * SLOTS_PER_BLOCK;
    localparam int IDLE_PCT       = 7;
    // Long enough to cover one full big-pool scan.
    localparam int SETTLE_CYCLES  = 3 + BIG_SLOTS + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  region;
        logic [3:0]  block_index;
        logic [2:0]  slot_index;
        logic [7:0]  offset;
        logic [31:0] size;
    } alloc_cmd_t;

    typedef struct packed {
        logic [1:0] out_region;
        logic [3:0] out_block;
        logic [2:0] out_slot;
        logic       moved;
        logic [8:0] copy_bytes;
        logic [7:0] stored_size;
        logic       known;
        logic       valid_res;
    } alloc_result_t;

    // Every input starts at a known value.
    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  mode        = '0;
    logic [1:0]  region      = '0;
    logic [3:0]  block_index = '0;
    logic [2:0]  slot_index  = '0;
    logic [7:0]  offset      = '0;
    logic [31:0] size        = '0;

    logic        busy;
    logic        done;
    logic [1:0]  out_region;
    logic [3:0]  out_block;
    logic [2:0]  out_slot;
    logic        moved;
    logic [8:0]  copy_bytes;
    logic [7:0]  stored_size;
    logic        known;
    logic        valid_res;

    // Local copy of the recorded sizes; zero marks a free slot.
    logic [3:0] small_held [SMALL_SLOTS];
    logic [7:0] big_held   [BIG_SLOTS];

    alloc_result_t pending_results [$];

    bit idle_enable    = 1'b1;
    int mismatch_count = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int moves_seen     = 0;
    int external_allocs = 0;
    int stall_cycles   = 0;

    two_pool_slot_size_allocator_core #(
        .BLOCKS      (BLOCKS),
        .SMALL_SLOTS (SMALL_SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .region      (region),
        .block_index (block_index),
        .slot_index  (slot_index),
        .offset      (offset),
        .size        (size),
        .done        (done),
        .out_region  (out_region),
        .out_block   (out_block),
        .out_slot    (out_slot),
        .moved       (moved),
        .copy_bytes  (copy_bytes),
        .stored_size (stored_size),
        .known       (known),
        .valid_res   (valid_res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Claim the first free slot for a fresh allocation: sizes 1..15 go to the
    // small pool only, 16..255 to the big pool (lowest block, then lowest slot).
    // Anything else, or a full pool, falls back to the external allocator.
    function automatic void claim_slot(input logic [31:0] sz, output logic [1:0] pool,
                                       output logic [3:0] blk, output logic [2:0] slt);
        int i;
        pool = REGION_EXT;
        blk  = '0;
        slt  = '0;
        if (sz == 0 || sz >= BIG_LIMIT)
            return;
        if (sz < SMALL_LIMIT)
        begin
            for (i = 0; i < SMALL_SLOTS; i++)
            begin
                if (small_held[i] == 0)
                begin
                    small_held[i] = sz[3:0];
                    pool = REGION_SMALL;
                    slt  = 3'(i);
                    return;
                end
            end
            return;
        end
        for (i = 0; i < BIG_SLOTS; i++)
        begin
            if (big_held[i] == 0)
            begin
                big_held[i] = sz[7:0];
                pool = REGION_BIG;
                blk  = 4'(i / SLOTS_PER_BLOCK);
                slt  = 3'(i % SLOTS_PER_BLOCK);
                return;
            end
        end
    endfunction

    // Apply one item to the local pools and return the result it must produce.
    function automatic alloc_result_t apply_cmd(input alloc_cmd_t c);
        alloc_result_t r;
        logic          in_small;
        logic          in_big;
        int            bi;
        logic [3:0]    old_small;
        logic [7:0]    held;
        logic [1:0]    pool;
        logic [3:0]    blk;
        logic [2:0]    slt;
        r        = '0;
        in_small = (c.region == REGION_SMALL) && (c.slot_index < SMALL_SLOTS);
        in_big   = (c.region == REGION_BIG) && (c.block_index < BLOCKS)
                   && (c.slot_index < SLOTS_PER_BLOCK);
        bi       = c.block_index * SLOTS_PER_BLOCK + c.slot_index;
        case (c.mode)
            MODE_ALLOC:
            begin
                claim_slot(c.size, pool, blk, slt);
                r.out_region = pool;
                r.out_block  = blk;
                r.out_slot   = slt;
            end
            MODE_REALLOC:
            begin
                if (in_small)
                begin
                    if (c.size < SMALL_LIMIT)
                    begin
                        // Resize in place; size zero leaves the slot free.
                        small_held[c.slot_index] = c.size[3:0];
                        r.out_region = REGION_SMALL;
                        r.out_slot   = c.slot_index;
                    end
                    else
                    begin
                        // Place anew while the old slot is still held, then drop it.
                        old_small = small_held[c.slot_index];
                        claim_slot(c.size, pool, blk, slt);
                        small_held[c.slot_index] = '0;
                        r.out_region = pool;
                        r.out_block  = blk;
                        r.out_slot   = slt;
                        r.moved      = 1'b1;
                        r.copy_bytes = 9'(old_small);
                    end
                end
                else if (in_big)
                begin
                    if (c.size < BIG_LIMIT)
                    begin
                        big_held[bi] = c.size[7:0];
                        r.out_region = REGION_BIG;
                        r.out_block  = c.block_index;
                        r.out_slot   = c.slot_index;
                    end
                    else
                    begin
                        // Too big for any pool: move out and copy the whole slot.
                        big_held[bi] = '0;
                        r.moved      = 1'b1;
                        r.copy_bytes = COPY_BIG;
                    end
                end
            end
            MODE_FREE:
            begin
                if (in_small)
                    small_held[c.slot_index] = '0;
                else if (in_big)
                    big_held[bi] = '0;
            end
            MODE_QUERY:
            begin
                if (in_small || in_big)
                begin
                    held          = in_small ? 8'(small_held[c.slot_index]) : big_held[bi];
                    r.stored_size = held;
                    r.known       = 1'b1;
                    r.valid_res   = c.offset < held;
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Capture each done strobe at the edge that ends its cycle; the block
    // cannot be held off, so every strobe must match the oldest prediction.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: region %0d block %0d slot %0d",
                       out_region, out_block, out_slot);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("out_region",  32'(want.out_region),  32'(out_region));
                compare_field("out_block",   32'(want.out_block),   32'(out_block));
                compare_field("out_slot",    32'(want.out_slot),    32'(out_slot));
                compare_field("moved",       32'(want.moved),       32'(moved));
                compare_field("copy_bytes",  32'(want.copy_bytes),  32'(copy_bytes));
                compare_field("stored_size", 32'(want.stored_size), 32'(stored_size));
                compare_field("known",       32'(want.known),       32'(known));
                compare_field("valid_res",   32'(want.valid_res),   32'(valid_res));
            end
        end
    end

    // Abort when neither side makes progress for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item accepted and no result for %0d cycles", stall_cycles);
            $display("FAILED: results differ");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic alloc_cmd_t make_cmd(input logic [1:0] m, input logic [1:0] rg,
                                            input logic [3:0] blk, input logic [2:0] slt,
                                            input logic [7:0] off, input logic [31:0] sz);
        alloc_cmd_t c;
        c.mode        = m;
        c.region      = rg;
        c.block_index = blk;
        c.slot_index  = slt;
        c.offset      = off;
        c.size        = sz;
        return c;
    endfunction

    // Hold start low for random idle cycles, then present the item until busy
    // drops at a rising edge. Called right after a rising edge.
    task automatic send_cmd(input alloc_cmd_t c);
        alloc_result_t r;
        while (idle_enable && $urandom_range(0, 99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= c.mode;
        region      <= c.region;
        block_index <= c.block_index;
        slot_index  <= c.slot_index;
        offset      <= c.offset;
        size        <= c.size;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // Accepted at this edge: predict now, in acceptance order.
        r = apply_cmd(c);
        pending_results.push_back(r);
        items_sent++;
        if (r.moved)
            moves_seen++;
        if (c.mode == MODE_ALLOC && r.out_region == REGION_EXT)
            external_allocs++;
    endtask

    // Drop start and hold off until every predicted result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Spread sizes over all pool classes, plus zero, oversize and full-width noise.
    function automatic logic [31:0] random_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 32'd0;
        if (roll < 40)
            return 32'($urandom_range(1, 15));
        if (roll < 80)
            return 32'($urandom_range(16, 255));
        if (roll < 90)
            return 32'($urandom_range(256, 65535));
        return $urandom;
    endfunction

    // Build a random item. Most items point at a slot that is currently held,
    // so realloc/free/query sequences exercise live state; the rest are noise.
    function automatic alloc_cmd_t random_cmd(input int alloc_pct, input int realloc_pct,
                                              input int free_pct);
        alloc_cmd_t c;
        int         roll;
        int         pick;
        int         live_slots [$];
        c.block_index = 4'($urandom_range(0, 15));
        c.slot_index  = 3'($urandom_range(0, 7));
        c.region      = 2'($urandom_range(0, 3));
        c.size        = random_size();
        c.offset      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            c.mode = MODE_ALLOC;
        else if (roll < alloc_pct + realloc_pct)
            c.mode = MODE_REALLOC;
        else if (roll < alloc_pct + realloc_pct + free_pct)
            c.mode = MODE_FREE;
        else
            c.mode = MODE_QUERY;
        if ($urandom_range(0, 99) < 85)
        begin
            // Small slots listed as 0..7, big slots as 100 + flat index.
            for (int i = 0; i < SMALL_SLOTS; i++)
                if (small_held[i] != 0)
                    live_slots.push_back(i);
            for (int i = 0; i < BIG_SLOTS; i++)
                if (big_held[i] != 0)
                    live_slots.push_back(100 + i);
            if (live_slots.size() != 0)
            begin
                pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
                if (pick < 100)
                begin
                    c.region     = REGION_SMALL;
                    c.slot_index = 3'(pick);
                end
                else
                begin
                    c.region      = REGION_BIG;
                    c.block_index = 4'((pick - 100) / SLOTS_PER_BLOCK);
                    c.slot_index  = 3'((pick - 100) % SLOTS_PER_BLOCK);
                end
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Size limits of alloc: zero, just past the big pool, all ones, and the
    // edges of both pool classes.
    task automatic test_alloc_limits();
        send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0, 32'd0));
        send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0, BIG_LIMIT));
        send_cmd(make_cmd(MODE_ALLOC, 2'd3, 4'd15, 3'd7, 8'd255, 32'hFFFF_FFFF));
        send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0, 32'd15));
        send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0, SMALL_LIMIT));
        send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0, 32'd255));
    endtask

    // Offset just inside and at the recorded size, a big slot index past the
    // block, and the unused pool code.
    task automatic test_query_cases();
        send_cmd(make_cmd(MODE_QUERY, REGION_SMALL, 4'd0, 3'd0, 8'd14, 32'd0));
        send_cmd(make_cmd(MODE_QUERY, REGION_SMALL, 4'd15, 3'd0, 8'd15, 32'd0));
        send_cmd(make_cmd(MODE_QUERY, REGION_BIG, 4'd0, 3'd5, 8'd0, 32'd0));
        send_cmd(make_cmd(MODE_QUERY, 2'd3, 4'd0, 3'd1, 8'd0, 32'd0));
    endtask

    // In-place resize, resize to zero, revive, move small to big, big in place,
    // big moved out, and an external pointer.
    task automatic test_realloc_cases();
        send_cmd(make_cmd(MODE_REALLOC, REGION_SMALL, 4'd0, 3'd0, 8'd0, 32'd9));
        send_cmd(make_cmd(MODE_REALLOC, REGION_SMALL, 4'd0, 3'd0, 8'd0, 32'd0));
        send_cmd(make_cmd(MODE_REALLOC, REGION_SMALL, 4'd0, 3'd0, 8'd0, 32'd5));
        send_cmd(make_cmd(MODE_REALLOC, REGION_SMALL, 4'd0, 3'd0, 8'd0, 32'd200));
        send_cmd(make_cmd(MODE_REALLOC, REGION_BIG, 4'd0, 3'd0, 8'd0, 32'd100));
        send_cmd(make_cmd(MODE_REALLOC, REGION_BIG, 4'd0, 3'd0, 8'd0, BIG_LIMIT));
        send_cmd(make_cmd(MODE_REALLOC, REGION_EXT, 4'd3, 3'd2, 8'd0, 32'd50));
    endtask

    task automatic test_free_cases();
        send_cmd(make_cmd(MODE_FREE, REGION_BIG, 4'd0, 3'd1, 8'd0, 32'd0));
    endtask

    // Fill the small pool, then show that one more small size goes external
    // rather than spilling into the big pool.
    task automatic test_small_pool_full();
        for (int i = 0; i <= SMALL_SLOTS; i++)
            send_cmd(make_cmd(MODE_ALLOC, REGION_EXT, 4'd0, 3'd0, 8'd0,
                              32'($urandom_range(1, 15))));
    endtask

    // Alloc-heavy traffic that drives both pools to full; pause once midway
    // until every result is back.
    task automatic test_random_fill();
        for (int i = 0; i < 250; i++)
        begin
            if (i == 125)
                wait_drained();
            send_cmd(random_cmd(60, 15, 5));
        end
        wait_drained();
    endtask

    // Balanced traffic that frees and reuses slots; the middle stretch runs
    // back to back with no idle cycles.
    task automatic test_random_churn();
        for (int i = 0; i < 300; i++)
        begin
            idle_enable = !(i >= 75 && i < 225);
            send_cmd(random_cmd(35, 25, 25));
        end
        idle_enable = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < SMALL_SLOTS; i++)
            small_held[i] = '0;
        for (int i = 0; i < BIG_SLOTS; i++)
            big_held[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_alloc_limits();
        test_query_cases();
        test_realloc_cases();
        test_free_cases();
        test_small_pool_full();
        wait_drained();
        test_random_fill();
        test_random_churn();

        // Give any stray strobe time to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d alloc/realloc/free/query items and checked %0d results.",
                 items_sent, results_seen);
        $display("Saw %0d moves on realloc and %0d allocations sent to the external pool.",
                 moves_seen, external_allocs);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
